// ===== src/mfu_pkg.sv =====
// Shared constants and types for the motor feedback unwrap block.
`timescale 1ns / 1ps
package mfu_pkg;

    localparam int unsigned MOTOR_COUNT_DEFAULT     = 8;
    localparam int unsigned COUNTS_PER_TURN_DEFAULT = 8192;

    localparam int unsigned ID_W      = 11;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NBYTES    = 6;
    localparam int unsigned MOTOR_W   = 4;
    localparam int unsigned ANGLE_W   = 13;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned STEP_W    = 14;
    localparam int unsigned TOTAL_W   = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [ID_W-1:0] BASE_ID_RESET = 11'h200;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic [MOTOR_W-1:0]             motor;
        logic                           bad;
        logic [LEN_W-1:0]               frame_length;
        logic [NBYTES-1:0][BYTE_W-1:0]  payload;
    } entry_t;

endpackage

// ===== src/mfu_front.sv =====
// Front end: identifier base register, request intake and motor classification.
`timescale 1ns / 1ps
module mfu_front #(
    parameter int unsigned MOTOR_COUNT = mfu_pkg::MOTOR_COUNT_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mfu_pkg::ID_W-1:0]      cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mfu_pkg::ID_W-1:0]      s_frame_id,
    input  logic [mfu_pkg::LEN_W-1:0]     s_frame_length,
    input  logic [mfu_pkg::BYTE_W-1:0]    s_byte_0,
    input  logic [mfu_pkg::BYTE_W-1:0]    s_byte_1,
    input  logic [mfu_pkg::BYTE_W-1:0]    s_byte_2,
    input  logic [mfu_pkg::BYTE_W-1:0]    s_byte_3,
    input  logic [mfu_pkg::BYTE_W-1:0]    s_byte_4,
    input  logic [mfu_pkg::BYTE_W-1:0]    s_byte_5,
    output logic                          push_valid,
    input  logic                          push_ready,
    output mfu_pkg::entry_t               push_entry
);

    localparam logic [mfu_pkg::ID_W-1:0] MOTOR_MAX = mfu_pkg::ID_W'(MOTOR_COUNT);

    logic [mfu_pkg::ID_W-1:0] base_id_reg;
    logic [mfu_pkg::ID_W-1:0] id_diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_id_reg <= mfu_pkg::BASE_ID_RESET;
        end else if (cfg_wr_en) begin
            base_id_reg <= cfg_wr_data;
        end
    end

    // Difference wraps modulo 2048 by width.
    assign id_diff = s_frame_id - base_id_reg;

    always_comb begin
        push_entry.motor        = id_diff[mfu_pkg::MOTOR_W-1:0];
        push_entry.bad          = (id_diff == '0) || (id_diff > MOTOR_MAX);
        push_entry.frame_length = s_frame_length;
        push_entry.payload[0]   = s_byte_0;
        push_entry.payload[1]   = s_byte_1;
        push_entry.payload[2]   = s_byte_2;
        push_entry.payload[3]   = s_byte_3;
        push_entry.payload[4]   = s_byte_4;
        push_entry.payload[5]   = s_byte_5;
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

// ===== src/mfu_queue.sv =====
// Two-entry queue between the classifying front end and the back end.
`timescale 1ns / 1ps
module mfu_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  mfu_pkg::entry_t   wr_entry,
    output logic              rd_valid,
    input  logic              rd_ready,
    output mfu_pkg::entry_t   rd_entry
);

    localparam int unsigned PTR_W = $clog2(mfu_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(mfu_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(mfu_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(mfu_pkg::QUEUE_DEPTH - 1);

    mfu_pkg::entry_t  slot_reg [mfu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== src/mfu_back.sv =====
// Back end: payload merge, angle unwrap per motor, position accumulate, output register.
`timescale 1ns / 1ps
module mfu_back #(
    parameter int unsigned MOTOR_COUNT     = mfu_pkg::MOTOR_COUNT_DEFAULT,
    parameter int unsigned COUNTS_PER_TURN = mfu_pkg::COUNTS_PER_TURN_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  mfu_pkg::entry_t                      q_entry,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mfu_pkg::MOTOR_W-1:0]          m_motor_number,
    output logic                                 m_bad_id,
    output logic [mfu_pkg::ANGLE_W-1:0]          m_angle,
    output logic signed [mfu_pkg::WORD_W-1:0]    m_speed_rpm,
    output logic signed [mfu_pkg::WORD_W-1:0]    m_torque_current,
    output logic signed [mfu_pkg::STEP_W-1:0]    m_angle_step,
    output logic signed [mfu_pkg::TOTAL_W-1:0]   m_total_position
);

    localparam int unsigned AW     = $clog2(COUNTS_PER_TURN);
    localparam int unsigned SW     = AW + 2;
    localparam int unsigned MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int unsigned RAW_W  = 2 * mfu_pkg::BYTE_W;
    localparam logic [RAW_W:0]         ANGLE_MAX = (RAW_W + 1)'(COUNTS_PER_TURN - 1);
    localparam logic signed [SW-1:0]   TURN_S    = SW'(COUNTS_PER_TURN);
    localparam logic signed [SW-1:0]   WRAP_S    = SW'(COUNTS_PER_TURN / 2 - 1);

    logic [mfu_pkg::BYTE_W-1:0] hold_reg [mfu_pkg::NBYTES];
    logic [AW-1:0]               last_angle_reg [MOTOR_COUNT];
    logic [mfu_pkg::TOTAL_W-1:0] turn_total_reg [MOTOR_COUNT];

    // Stage A registers
    logic                        s1_valid_reg;
    logic [mfu_pkg::MOTOR_W-1:0] s1_motor_reg;
    logic                        s1_bad_reg;
    logic [MIDX_W-1:0]           s1_midx_reg;
    logic [AW-1:0]               s1_angle_reg;
    logic [mfu_pkg::WORD_W-1:0]  s1_speed_reg;
    logic [mfu_pkg::WORD_W-1:0]  s1_current_reg;
    logic signed [SW-1:0]        s1_step_reg;

    // Output registers
    logic                        m_valid_reg;
    logic [mfu_pkg::MOTOR_W-1:0] m_motor_reg;
    logic                        m_bad_reg;
    logic [mfu_pkg::ANGLE_W-1:0] m_angle_reg;
    logic [mfu_pkg::WORD_W-1:0]  m_speed_reg;
    logic [mfu_pkg::WORD_W-1:0]  m_current_reg;
    logic [mfu_pkg::STEP_W-1:0]  m_step_reg;
    logic [mfu_pkg::TOTAL_W-1:0] m_total_reg;

    logic [mfu_pkg::BYTE_W-1:0]  merged [mfu_pkg::NBYTES];
    logic [RAW_W-1:0]            raw_angle;
    logic [AW-1:0]               angle;
    logic [MIDX_W-1:0]           midx;
    logic [AW-1:0]               last_angle;
    logic signed [SW-1:0]        diff_s, wrap_hi, step_raw, step;
    logic [mfu_pkg::TOTAL_W-1:0] total_sum;
    logic                        a_fire, b_fire;

    assign b_fire  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign q_ready = !s1_valid_reg || b_fire;
    assign a_fire  = q_valid && q_ready;

    // Short frames keep the held bytes past their length.
    always_comb begin
        for (int i = 0; i < mfu_pkg::NBYTES; i++) begin
            merged[i] = (mfu_pkg::LEN_W'(i) < q_entry.frame_length) ?
                        q_entry.payload[i] : hold_reg[i];
        end
    end

    assign raw_angle = {merged[0], merged[1]};
    assign angle     = ({1'b0, raw_angle} > ANGLE_MAX) ? ANGLE_MAX[AW-1:0] : raw_angle[AW-1:0];
    assign midx      = MIDX_W'(q_entry.motor - 1'b1);
    assign last_angle = last_angle_reg[midx];

    // Wrap in two ordered steps, as a step near half a turn can fold back.
    always_comb begin
        diff_s   = $signed({2'b00, angle}) - $signed({2'b00, last_angle});
        wrap_hi  = (diff_s >= WRAP_S) ? diff_s - TURN_S : diff_s;
        step_raw = (wrap_hi <= -WRAP_S) ? wrap_hi + TURN_S : wrap_hi;
        step     = (q_entry.bad || last_angle == '0) ? '0 : step_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mfu_pkg::NBYTES; i++) begin
                hold_reg[i] <= '0;
            end
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                last_angle_reg[i] <= '0;
            end
        end else if (a_fire && !q_entry.bad) begin
            for (int i = 0; i < mfu_pkg::NBYTES; i++) begin
                hold_reg[i] <= merged[i];
            end
            last_angle_reg[midx] <= angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (q_ready) begin
            s1_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            s1_motor_reg   <= q_entry.motor;
            s1_bad_reg     <= q_entry.bad;
            s1_midx_reg    <= midx;
            s1_angle_reg   <= angle;
            s1_speed_reg   <= {merged[2], merged[3]};
            s1_current_reg <= {merged[4], merged[5]};
            s1_step_reg    <= step;
        end
    end

    assign total_sum = turn_total_reg[s1_midx_reg] + mfu_pkg::TOTAL_W'(s1_step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                turn_total_reg[i] <= '0;
            end
        end else if (b_fire && !s1_bad_reg) begin
            turn_total_reg[s1_midx_reg] <= total_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire) begin
            m_motor_reg   <= s1_motor_reg;
            m_bad_reg     <= s1_bad_reg;
            m_angle_reg   <= mfu_pkg::ANGLE_W'(s1_angle_reg);
            m_speed_reg   <= s1_speed_reg;
            m_current_reg <= s1_current_reg;
            m_step_reg    <= mfu_pkg::STEP_W'(s1_step_reg);
            m_total_reg   <= s1_bad_reg ? '0 : total_sum;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_motor_number   = m_motor_reg;
    assign m_bad_id         = m_bad_reg;
    assign m_angle          = m_angle_reg;
    assign m_speed_rpm      = $signed(m_speed_reg);
    assign m_torque_current = $signed(m_current_reg);
    assign m_angle_step     = $signed(m_step_reg);
    assign m_total_position = $signed(m_total_reg);

endmodule

// ===== src/motor_feedback_unwrap_top.sv =====
// A request passes the queue, the stage A registers and the output register in order.
// Throughput: one request per cycle while the output is not held back; the per-motor
// angle and position updates add no stall between consecutive frames for one motor.
// Reset (synchronous, active low): base identifier returns to 0x200, per-motor angles,
// positions and the held payload clear to zero, and the queue and pipeline empty.
`timescale 1ns / 1ps
module motor_feedback_unwrap_top #(
    parameter int unsigned MOTOR_COUNT     = mfu_pkg::MOTOR_COUNT_DEFAULT,
    parameter int unsigned COUNTS_PER_TURN = mfu_pkg::COUNTS_PER_TURN_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [mfu_pkg::ID_W-1:0]             cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mfu_pkg::ID_W-1:0]             s_frame_id,
    input  logic [mfu_pkg::LEN_W-1:0]            s_frame_length,
    input  logic [mfu_pkg::BYTE_W-1:0]           s_byte_0,
    input  logic [mfu_pkg::BYTE_W-1:0]           s_byte_1,
    input  logic [mfu_pkg::BYTE_W-1:0]           s_byte_2,
    input  logic [mfu_pkg::BYTE_W-1:0]           s_byte_3,
    input  logic [mfu_pkg::BYTE_W-1:0]           s_byte_4,
    input  logic [mfu_pkg::BYTE_W-1:0]           s_byte_5,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mfu_pkg::MOTOR_W-1:0]          m_motor_number,
    output logic                                 m_bad_id,
    output logic [mfu_pkg::ANGLE_W-1:0]          m_angle,
    output logic signed [mfu_pkg::WORD_W-1:0]    m_speed_rpm,
    output logic signed [mfu_pkg::WORD_W-1:0]    m_torque_current,
    output logic signed [mfu_pkg::STEP_W-1:0]    m_angle_step,
    output logic signed [mfu_pkg::TOTAL_W-1:0]   m_total_position
);

    logic            push_valid, push_ready;
    mfu_pkg::entry_t push_entry;
    logic            q_valid, q_ready;
    mfu_pkg::entry_t q_entry;

    mfu_front #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_id     (s_frame_id),
        .s_frame_length (s_frame_length),
        .s_byte_0       (s_byte_0),
        .s_byte_1       (s_byte_1),
        .s_byte_2       (s_byte_2),
        .s_byte_3       (s_byte_3),
        .s_byte_4       (s_byte_4),
        .s_byte_5       (s_byte_5),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_entry     (push_entry)
    );

    mfu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_entry (q_entry)
    );

    mfu_back #(
        .MOTOR_COUNT     (MOTOR_COUNT),
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_entry          (q_entry),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_motor_number   (m_motor_number),
        .m_bad_id         (m_bad_id),
        .m_angle          (m_angle),
        .m_speed_rpm      (m_speed_rpm),
        .m_torque_current (m_torque_current),
        .m_angle_step     (m_angle_step),
        .m_total_position (m_total_position)
    );

    // A rejected identifier never moves a position.
    a_bad_id_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_id |-> m_angle_step == '0 && m_total_position == '0)
        else $error("bad identifier result carries a step or position");

    // No result right after reset is released.
    a_empty_after_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_valid)
        else $error("result valid straight out of reset");

    // Angle stays within one turn after clamping.
    a_angle_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_angle) <= 32'(COUNTS_PER_TURN - 1))
        else $error("angle above one turn");

endmodule

// ===== sim/motor_feedback_unwrap_top_tb.sv =====
// Self-checking testbench for the motor feedback unwrap block.
`timescale 1ns / 1ps
module motor_feedback_unwrap_top_tb;

    localparam int unsigned ID_W    = mfu_pkg::ID_W;
    localparam int unsigned LEN_W   = mfu_pkg::LEN_W;
    localparam int unsigned BYTE_W  = mfu_pkg::BYTE_W;
    localparam int unsigned NBYTES  = mfu_pkg::NBYTES;
    localparam int unsigned MOTOR_W = mfu_pkg::MOTOR_W;
    localparam int unsigned ANGLE_W = mfu_pkg::ANGLE_W;
    localparam int unsigned WORD_W  = mfu_pkg::WORD_W;
    localparam int unsigned STEP_W  = mfu_pkg::STEP_W;
    localparam int unsigned TOTAL_W = mfu_pkg::TOTAL_W;

    localparam int MOTORS     = mfu_pkg::MOTOR_COUNT_DEFAULT;
    localparam int TURN       = mfu_pkg::COUNTS_PER_TURN_DEFAULT;
    localparam int WRAP_EDGE  = TURN / 2 - 1;
    localparam int MAX_ANGLE  = TURN - 1;
    localparam int RUN_LIMIT  = 400000;
    localparam int PHASE_LEN  = 160;
    localparam int HOLDOFF    = 300;

    typedef struct packed {
        logic [ID_W-1:0]               id;
        logic [LEN_W-1:0]              len;
        logic [NBYTES-1:0][BYTE_W-1:0] data;
    } frame_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic               bad;
        logic [ANGLE_W-1:0] angle;
        logic [WORD_W-1:0]  speed;
        logic [WORD_W-1:0]  current;
        logic [STEP_W-1:0]  step;
        logic [TOTAL_W-1:0] total;
    } feedback_t;

    typedef enum int {RX_STREAM, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [ID_W-1:0]     cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ID_W-1:0]     s_frame_id = '0;
    logic [LEN_W-1:0]    s_frame_length = '0;
    logic [BYTE_W-1:0]   s_byte_0 = '0;
    logic [BYTE_W-1:0]   s_byte_1 = '0;
    logic [BYTE_W-1:0]   s_byte_2 = '0;
    logic [BYTE_W-1:0]   s_byte_3 = '0;
    logic [BYTE_W-1:0]   s_byte_4 = '0;
    logic [BYTE_W-1:0]   s_byte_5 = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [MOTOR_W-1:0]  m_motor_number;
    logic                m_bad_id;
    logic [ANGLE_W-1:0]  m_angle;
    logic signed [WORD_W-1:0]  m_speed_rpm;
    logic signed [WORD_W-1:0]  m_torque_current;
    logic signed [STEP_W-1:0]  m_angle_step;
    logic signed [TOTAL_W-1:0] m_total_position;

    // Unwrapper state as the block should hold it
    logic [ID_W-1:0]    base_id_q;
    logic [ANGLE_W-1:0] last_angle_q [16];
    logic [TOTAL_W-1:0] turn_pos_q [16];
    logic [BYTE_W-1:0]  held_bytes [NBYTES];

    feedback_t pending_feedback [$];
    int        mismatches = 0;
    int        frames_sent = 0;
    int        results_seen = 0;
    int        bad_ids = 0;
    int        short_frames = 0;
    int        wrapped_steps = 0;
    int        bases_used = 1;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        holdoff_request = 0;

    motor_feedback_unwrap_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_id       (s_frame_id),
        .s_frame_length   (s_frame_length),
        .s_byte_0         (s_byte_0),
        .s_byte_1         (s_byte_1),
        .s_byte_2         (s_byte_2),
        .s_byte_3         (s_byte_3),
        .s_byte_4         (s_byte_4),
        .s_byte_5         (s_byte_5),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_motor_number   (m_motor_number),
        .m_bad_id         (m_bad_id),
        .m_angle          (m_angle),
        .m_speed_rpm      (m_speed_rpm),
        .m_torque_current (m_torque_current),
        .m_angle_step     (m_angle_step),
        .m_total_position (m_total_position)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_feedback.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void clear_unwrap_state();
        int i;
        base_id_q = mfu_pkg::BASE_ID_RESET;
        for (i = 0; i < 16; i++) begin
            last_angle_q[i] = '0;
            turn_pos_q[i] = '0;
        end
        for (i = 0; i < NBYTES; i++) held_bytes[i] = '0;
    endfunction

    // Decode one frame, unwrap its angle and advance the per-motor position.
    function automatic feedback_t unwrap_frame(frame_t f);
        feedback_t r;
        logic [ID_W-1:0]   diff;
        logic [BYTE_W-1:0] b [NBYTES];
        logic [15:0]       raw;
        int                d;
        int                d_raw;
        int                m;
        int                i;
        diff = f.id - base_id_q;
        r.motor = diff[MOTOR_W-1:0];
        r.bad = (diff < 1) || (diff > MOTORS);
        for (i = 0; i < NBYTES; i++) b[i] = (i < f.len) ? f.data[i] : held_bytes[i];
        raw = {b[0], b[1]};
        r.angle = (raw > MAX_ANGLE) ? ANGLE_W'(MAX_ANGLE) : raw[ANGLE_W-1:0];
        r.speed = {b[2], b[3]};
        r.current = {b[4], b[5]};
        d = 0;
        r.total = '0;
        if (f.len < NBYTES) short_frames++;
        if (r.bad) begin
            bad_ids++;
        end else begin
            m = diff[MOTOR_W-1:0];
            if (last_angle_q[m] != 0) begin
                d = r.angle;
                d = d - int'(last_angle_q[m]);
                d_raw = d;
                if (d >= WRAP_EDGE) d -= TURN;
                if (d <= -WRAP_EDGE) d += TURN;
                if (d != d_raw) wrapped_steps++;
            end
            turn_pos_q[m] = turn_pos_q[m] + TOTAL_W'(d);
            last_angle_q[m] = r.angle;
            r.total = turn_pos_q[m];
            for (i = 0; i < NBYTES; i++) held_bytes[i] = b[i];
        end
        r.step = d[STEP_W-1:0];
        return r;
    endfunction

    function automatic frame_t make_frame(int id, int len, int raw_angle, int speed, int current);
        frame_t f;
        f.id = id[ID_W-1:0];
        f.len = len[LEN_W-1:0];
        f.data[0] = raw_angle[15:8];
        f.data[1] = raw_angle[7:0];
        f.data[2] = speed[15:8];
        f.data[3] = speed[7:0];
        f.data[4] = current[15:8];
        f.data[5] = current[7:0];
        return f;
    endfunction

    // Mostly well-formed frames that walk each motor's angle; the rest is noise.
    function automatic frame_t random_frame();
        frame_t f;
        int     motor;
        int     a;
        int     len;
        if ($urandom_range(0, 4) == 0) begin
            f.id = $urandom_range(0, 2047);
            f.len = $urandom_range(0, 8);
            f.data = {16'($urandom), 32'($urandom)};
            return f;
        end
        motor = $urandom_range(1, MOTORS);
        case ($urandom_range(0, 9))
            0: a = $urandom_range(0, 16'hFFFF);
            1, 2: a = (int'(last_angle_q[motor]) + $urandom_range(0, 8400) - 4200) & MAX_ANGLE;
            default: a = (int'(last_angle_q[motor]) + $urandom_range(0, 600) - 300) & MAX_ANGLE;
        endcase
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 8);
        return make_frame(int'(base_id_q) + motor, len, a, $urandom_range(0, 16'hFFFF),
                          $urandom_range(0, 16'hFFFF));
    endfunction

    // Hold the request until accepted; predict at the accepting edge.
    task automatic send_frame(frame_t f);
        s_valid <= 1'b1;
        s_frame_id <= f.id;
        s_frame_length <= f.len;
        s_byte_0 <= f.data[0];
        s_byte_1 <= f.data[1];
        s_byte_2 <= f.data[2];
        s_byte_3 <= f.data[3];
        s_byte_4 <= f.data[4];
        s_byte_5 <= f.data[5];
        do @(posedge aclk); while (!s_ready);
        pending_feedback.push_back(unwrap_frame(f));
        frames_sent++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic offer(frame_t f);
        send_frame(f);
        pace_sender();
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_feedback.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_base(int value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[ID_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        base_id_q = value[ID_W-1:0];
        bases_used++;
        @(posedge aclk);
    endtask

    // Receiver: switch between ready patterns; honor a requested long hold-off.
    initial begin : ready_pattern
        rx_mode_t ready_mode;
        int       mode_left;
        int       hold_left;
        ready_mode = RX_STREAM;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (holdoff_request > 0) begin
                hold_left = holdoff_request;
                holdoff_request = 0;
                m_ready <= 1'b0;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
            end
            if (mode_left == 0) begin
                ready_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (ready_mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        feedback_t want;
        feedback_t got;
        if (aresetn && m_valid && m_ready) begin
            got.motor = m_motor_number;
            got.bad = m_bad_id;
            got.angle = m_angle;
            got.speed = m_speed_rpm;
            got.current = m_torque_current;
            got.step = m_angle_step;
            got.total = m_total_position;
            results_seen++;
            if (pending_feedback.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d: motor %0d angle %0d",
                             cycle_count, got.motor, got.angle);
            end else begin
                want = pending_feedback.pop_front();
                if (got.motor !== want.motor || got.bad !== want.bad ||
                    got.angle !== want.angle || got.speed !== want.speed ||
                    got.current !== want.current || got.step !== want.step ||
                    got.total !== want.total) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d (expected / actual):", cycle_count);
                        $display("  motor %0d/%0d bad %0d/%0d angle %0d/%0d",
                                 want.motor, got.motor, want.bad, got.bad,
                                 want.angle, got.angle);
                        $display("  speed %0d/%0d current %0d/%0d",
                                 $signed(want.speed), $signed(got.speed),
                                 $signed(want.current), $signed(got.current));
                        $display("  step %0d/%0d total %0d/%0d",
                                 $signed(want.step), $signed(got.step),
                                 $signed(want.total), $signed(got.total));
                    end
                end
            end
        end
    end

    task automatic test_reset_defaults();
        offer(make_frame(512, 8, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        offer(make_frame(513, 6, 0, 0, 0));
        offer(make_frame(520, 6, 1234, 16'h8000, 16'h7FFF));
        offer(make_frame(521, 6, 77, 16'h7FFF, 16'h8000));
        offer(make_frame(511, 8, 500, 1, 16'hFFFF));
        wait_idle();
    endtask

    task automatic test_short_frames();
        offer(make_frame(516, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        offer(make_frame(516, 3, 16'hAABB, 16'hCCDD, 16'hEEFF));
        // bad identifier must leave the held payload alone
        offer(make_frame(523, 6, 16'h0102, 16'h0304, 16'h0506));
        offer(make_frame(516, 1, 16'h1F00, 0, 0));
        wait_idle();
    endtask

    task automatic test_angle_wrap();
        int angles [12] = '{100, 4195, 99, 4196, 8191, 3, 4097, 2, 0, 5000,
                            16'hFFFF, 4093};
        int k;
        for (k = 0; k < 12; k++)
            offer(make_frame(515, 6, angles[k], 16'h1000 + k, 16'hF000 - k));
        wait_idle();
    endtask

    task automatic test_base_extremes();
        write_base(0);
        offer(make_frame(0, 6, 10, 2, 3));
        offer(make_frame(8, 6, 20, 4, 5));
        write_base(2047);
        offer(make_frame(7, 6, 30, 6, 7));
        offer(make_frame(2046, 6, 40, 8, 9));
        // identifier below base wraps into motor range
        write_base(2040);
        offer(make_frame(0, 6, 50, 10, 11));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int bases [8];
        int p;
        int k;
        bases = '{$urandom_range(0, 2047), 0, 2047, 512, $urandom_range(0, 2047),
                  2043, $urandom_range(0, 2047), $urandom_range(0, 2047)};
        for (p = 0; p < 8; p++) begin
            write_base(bases[p]);
            for (k = 0; k < PHASE_LEN; k++) offer(random_frame());
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        int k;
        holdoff_request = HOLDOFF;
        for (k = 0; k < 40; k++) send_frame(random_frame());
        wait_idle();
    endtask

    task automatic finish_run();
        wait_idle();
        repeat (8) @(posedge aclk);
        $display("covered %0d frames over %0d identifier bases, %0d results checked",
                 frames_sent, bases_used, results_seen);
        $display("including %0d bad identifiers, %0d short frames, %0d wrapped steps",
                 bad_ids, short_frames, wrapped_steps);
        if (mismatches == 0 && pending_feedback.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    endtask

    initial begin
        clear_unwrap_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_short_frames();
        test_angle_wrap();
        test_base_extremes();
        test_random_traffic();
        test_backpressure();
        finish_run();
    end

endmodule
